### src/pica_pkg.sv
package pica_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_WINDUP_GAIN   = 3'd2;
    localparam logic [2:0] REG_STEP_TIME     = 3'd3;
    localparam logic [2:0] REG_DRIVE_MIN     = 3'd4;
    localparam logic [2:0] REG_DRIVE_MAX     = 3'd5;

    // Request codes
    localparam logic REQ_STEP  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_UNSAT     = 4'd1;
    localparam logic [OP_W-1:0] OP_CLAMP     = 4'd2;
    localparam logic [OP_W-1:0] OP_TERM_LOAD = 4'd3;
    localparam logic [OP_W-1:0] OP_TERM_ADD  = 4'd4;
    localparam logic [OP_W-1:0] OP_INC_LOAD  = 4'd5;
    localparam logic [OP_W-1:0] OP_INC_ADD   = 4'd6;
    localparam logic [OP_W-1:0] OP_FINISH    = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

    // Multiplier operand selects
    localparam logic [1:0] A_ERR  = 2'd0;
    localparam logic [1:0] A_DIFF = 2'd1;
    localparam logic [1:0] A_THI  = 2'd2;
    localparam logic [1:0] A_TLO  = 2'd3;

    localparam logic [1:0] B_KP  = 2'd0;
    localparam logic [1:0] B_KI  = 2'd1;
    localparam logic [1:0] B_KAW = 2'd2;
    localparam logic [1:0] B_DT  = 2'd3;

    // Sequencing
    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;
    localparam logic [1:0] JMP_HOME     = 2'd3;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_UNSAT  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CLAMP  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_KI     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_KAW    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_THI    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_TLO    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FINISH = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [1:0]        a_sel;
        logic [1:0]        b_sel;
        logic [1:0]        jump;
        logic [STEP_W-1:0] target;
    } uword_t;

    // Microprogram. The waiting step branches to the clear routine on a clear request.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{op: OP_NOP, a_sel: A_ERR, b_sel: B_KP, jump: JMP_HOME, target: STEP_IDLE};
        case (step)
            STEP_IDLE:
                w = '{op: OP_NOP, a_sel: A_ERR, b_sel: B_KP, jump: JMP_WAIT_IN,
                      target: STEP_UNSAT};
            STEP_UNSAT:
                w = '{op: OP_UNSAT, a_sel: A_ERR, b_sel: B_KP, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_CLAMP:
                w = '{op: OP_CLAMP, a_sel: A_ERR, b_sel: B_KP, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_KI:
                w = '{op: OP_TERM_LOAD, a_sel: A_ERR, b_sel: B_KI, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_KAW:
                w = '{op: OP_TERM_ADD, a_sel: A_DIFF, b_sel: B_KAW, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_THI:
                w = '{op: OP_INC_LOAD, a_sel: A_THI, b_sel: B_DT, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_TLO:
                w = '{op: OP_INC_ADD, a_sel: A_TLO, b_sel: B_DT, jump: JMP_NEXT,
                      target: STEP_IDLE};
            STEP_FINISH:
                w = '{op: OP_FINISH, a_sel: A_ERR, b_sel: B_KP, jump: JMP_WAIT_OUT,
                      target: STEP_IDLE};
            STEP_CLEAR:
                w = '{op: OP_CLEAR, a_sel: A_ERR, b_sel: B_KP, jump: JMP_WAIT_OUT,
                      target: STEP_IDLE};
            default:
                w = '{op: OP_NOP, a_sel: A_ERR, b_sel: B_KP, jump: JMP_HOME,
                      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/pi_controller_antiwindup.sv
// PI controller with back-calculation anti-windup, fixed point.
//
// Input channel: in_valid/in_stall carry req_type and loop_error. A step
// request returns the clamped drive and a clamp flag; a clear request zeroes
// the integrator and returns a drive of zero.
// Output channel: out_valid/out_stall carry drive and clamped from a result
// register, so a new request can be taken while a result still waits.
// A microprogram drives one shared 43 x 17 bit multiplier: a step request
// runs through the steps UNSAT, CLAMP, KI, KAW, THI, TLO and FINISH to the
// result register, a clear request through CLEAR alone. One request is in
// work at a time. The last step waits while the result register is full and
// the receiver stalls; in_stall stays high until the sequencer is back at its
// first step. Reset clears the integrator and the sequencer, empties the
// result register and loads the gains and limits with their defaults (unity
// proportional gain, other gains and the sample period zero, full-range
// limits). Configuration is written through cfg_we/cfg_index/cfg_data by the
// user only while idle; the block itself does not enforce this.
module pi_controller_antiwindup
    import pica_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic signed [15:0] loop_error,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] drive,
    output logic               clamped
);

    logic [15:0]        prop_gain_reg, integral_gain_reg, windup_gain_reg, step_time_reg;
    logic signed [15:0] drive_min_reg, drive_max_reg;

    logic [STEP_W-1:0]  step_reg, step_next;
    uword_t             uw;

    logic signed [15:0] err_reg;
    logic signed [41:0] unsat_reg, unsat_next;
    logic signed [31:0] sat_reg;
    logic               clip_reg;
    logic signed [41:0] diff_reg, diff_next;
    logic signed [59:0] term_reg, term_next;
    logic signed [51:0] inc_reg, inc_next;
    logic signed [31:0] integ_reg, integ_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] drive_reg, drive_next;
    logic               clamped_reg, clamped_next;

    logic signed [42:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [59:0] prod;

    logic signed [41:0] lo_w, hi_w, sat_w;
    logic signed [52:0] sum_w;
    logic               in_take, out_free, write_out;

    assign uw       = ucode(step_reg);
    assign in_stall = (uw.jump != JMP_WAIT_IN);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign write_out = (uw.jump == JMP_WAIT_OUT) && out_free;

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= 16'd256;
            integral_gain_reg <= 16'd0;
            windup_gain_reg   <= 16'd0;
            step_time_reg     <= 16'd0;
            drive_min_reg     <= 16'sh8000;
            drive_max_reg     <= 16'sh7FFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                REG_WINDUP_GAIN:   windup_gain_reg   <= cfg_data;
                REG_STEP_TIME:     step_time_reg     <= cfg_data;
                REG_DRIVE_MIN:     drive_min_reg     <= cfg_data;
                REG_DRIVE_MAX:     drive_max_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        step_next = step_reg;
        case (uw.jump)
            JMP_NEXT:
                step_next = step_reg + 1'b1;
            JMP_WAIT_IN:
                if (in_take)
                    step_next = (req_type == REQ_CLEAR) ? STEP_CLEAR : uw.target;
            JMP_WAIT_OUT:
                if (out_free)
                    step_next = uw.target;
            default:
                step_next = STEP_IDLE;
        endcase
    end

    // Shared multiplier
    always_comb
    begin
        case (uw.a_sel)
            A_ERR:   mul_a = {{27{err_reg[15]}}, err_reg};
            A_DIFF:  mul_a = {diff_reg[41], diff_reg};
            A_THI:   mul_a = {{7{term_reg[59]}}, term_reg[59:24]};
            default: mul_a = {19'd0, term_reg[23:0]};
        endcase
        case (uw.b_sel)
            B_KP:    mul_b = {1'b0, prop_gain_reg};
            B_KI:    mul_b = {1'b0, integral_gain_reg};
            B_KAW:   mul_b = {1'b0, windup_gain_reg};
            default: mul_b = {1'b0, step_time_reg};
        endcase
    end

    assign prod = mul_a * mul_b;

    // Clamp limits scaled to the 2^-31 grid of the integrator.
    assign lo_w = {{10{drive_min_reg[15]}}, drive_min_reg, 16'd0};
    assign hi_w = {{10{drive_max_reg[15]}}, drive_max_reg, 16'd0};

    always_comb
    begin
        if (unsat_reg < lo_w)
            sat_w = lo_w;
        else if (unsat_reg > hi_w)
            sat_w = hi_w;
        else
            sat_w = unsat_reg;
    end

    assign sum_w = {inc_reg[51], inc_reg} + {{21{integ_reg[31]}}, integ_reg};

    // Datapath
    always_comb
    begin
        unsat_next     = unsat_reg;
        diff_next      = diff_reg;
        term_next      = term_reg;
        inc_next       = inc_reg;
        integ_next     = integ_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (uw.op)
            OP_UNSAT:
                unsat_next = $signed({prod[33:0], 8'd0}) +
                             {{10{integ_reg[31]}}, integ_reg};
            OP_CLAMP:
                diff_next = sat_w - unsat_reg;
            OP_TERM_LOAD:
                term_next = $signed({prod[43:0], 16'd0});
            OP_TERM_ADD:
                term_next = term_reg + prod;
            OP_INC_LOAD:
                inc_next = prod[51:0];
            OP_INC_ADD:
                // The low part of the split product is floored at the 2^-24 point.
                inc_next = inc_reg + $signed({36'd0, prod[39:24]});
            OP_FINISH:
                if (write_out)
                begin
                    if (!sum_w[52] && (|sum_w[51:31]))
                        integ_next = 32'sh7FFFFFFF;
                    else if (sum_w[52] && !(&sum_w[51:31]))
                        integ_next = 32'sh80000000;
                    else
                        integ_next = sum_w[31:0];
                    // Round to nearest with ties upward.
                    drive_next     = sat_reg[31:16] + {15'd0, sat_reg[15]};
                    clamped_next   = clip_reg;
                    out_valid_next = 1'b1;
                end
            OP_CLEAR:
                if (write_out)
                begin
                    integ_next     = '0;
                    drive_next     = '0;
                    clamped_next   = 1'b0;
                    out_valid_next = 1'b1;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_IDLE;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            err_reg <= loop_error;
        if (uw.op == OP_CLAMP)
        begin
            sat_reg  <= sat_w[31:0];
            clip_reg <= (sat_w != unsat_reg);
        end
        unsat_reg   <= unsat_next;
        diff_reg    <= diff_next;
        term_reg    <= term_next;
        inc_reg     <= inc_next;
        drive_reg   <= drive_next;
        clamped_reg <= clamped_next;
    end

endmodule

### src/pica_checker.sv
module pica_checker
    import pica_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               req_type,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] drive,
    input logic               clamped
);

    // A result held back by the receiver keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("result changed while stalled");

    // One request is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken during work");

    // A clear request with a free result register answers zero through the clear step.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_CLEAR) && !out_valid
        |=> ##1 out_valid && (drive == 16'sd0) && !clamped)
        else $error("clear request did not answer zero");

endmodule

bind pi_controller_antiwindup pica_checker u_pica_checker (.*);

### verif/testbench.sv
module testbench;
    import pica_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 9;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 80;
    localparam int PHASES = 13;
    localparam int PHASE_ITEMS = 50;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               clamped;
    } ctl_out_t;

    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic               rt;
        logic signed [15:0] err;
        logic               typed;
        ctl_out_t           want;
    } row_t;

    // Register writes and requests walked in order; typed rows carry their own answer.
    localparam int PLAN_LEN = 43;
    localparam row_t PLAN [PLAN_LEN] = '{
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd32767,  1'b1, '{16'sd32767, 1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sh8000,   1'b1, '{16'sh8000,  1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd0,      1'b1, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd1,      1'b1, '{16'sd1,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_CLEAR, 16'sd0,      1'b1, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PROP_GAIN,     16'hFFFF, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_INTEGRAL_GAIN, 16'hFFFF, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_WINDUP_GAIN,   16'hFFFF, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_STEP_TIME,     16'hFFFF, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd32767,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd32767,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_WINDUP_GAIN,   16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sh8000,   1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sh8000,   1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_CLEAR, 16'sh7FFF,   1'b1, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PROP_GAIN,     16'h0100, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MIN,     16'h03E8, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MAX,     16'hFC18, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd5000,   1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  -16'sd5000,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_UNUSED,        16'hFFFF, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd12345,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_INTEGRAL_GAIN, 16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_WINDUP_GAIN,   16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_STEP_TIME,     16'h0000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MIN,     16'hFF9C, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MAX,     16'h0064, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sh8000,   1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd32767,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PROP_GAIN,     16'h0100, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_INTEGRAL_GAIN, 16'h1000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_WINDUP_GAIN,   16'h0200, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_STEP_TIME,     16'h8000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MIN,     16'hC000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DRIVE_MAX,     16'h4000, REQ_STEP,  16'sd0,      1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd20000,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd20000,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  16'sd20000,  1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  -16'sd30000, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_STEP,  -16'sd30000, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_ITEM,  REG_PROP_GAIN,     16'h0000, REQ_CLEAR, 16'sh8000,   1'b1, '{16'sd0,     1'b0}}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               req_type;
    logic signed [15:0] loop_error;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] drive;
    logic               clamped;

    // Predictor copy of the registers and the integrator.
    logic [15:0]        kp_set;
    logic [15:0]        ki_set;
    logic [15:0]        kaw_set;
    logic [15:0]        dt_set;
    logic signed [15:0] out_lo;
    logic signed [15:0] out_hi;
    logic signed [31:0] integ_q;

    ctl_out_t expected_q[$];
    int errors;
    int items_sent;
    int clears_sent;
    int reg_writes;
    int results_seen;
    int clamp_hits;
    int sat_hits;
    bit send_gaps;
    bit recv_gaps;
    bit long_hold_req;

    pi_controller_antiwindup DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .loop_error (loop_error),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .clamped    (clamped)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic ctl_out_t pi_predict(input logic rt, input logic signed [15:0] err);
        longint e;
        longint unsat;
        longint sat;
        longint lo;
        longint hi;
        longint term;
        longint thi;
        longint tlo;
        longint inc;
        longint acc;
        longint dt;
        ctl_out_t r;
        r = '0;
        if (rt == REQ_CLEAR) begin
            integ_q = '0;
            return r;
        end
        e = longint'(err);
        dt = longint'(dt_set);
        unsat = longint'(kp_set) * e * 256 + longint'(integ_q);
        lo = longint'(out_lo) * 65536;
        hi = longint'(out_hi) * 65536;
        // With inverted limits, a value below the lower limit takes it and any other the upper.
        if (unsat < lo)
            sat = lo;
        else if (unsat > hi)
            sat = hi;
        else
            sat = unsat;
        r.clamped = (sat != unsat);
        if (r.clamped)
            clamp_hits++;
        term = longint'(ki_set) * e * 65536 + longint'(kaw_set) * (sat - unsat);
        // Split the product so that it stays in 64 bits; the shift floors.
        thi = term >>> 24;
        tlo = term - thi * 64'sd16777216;
        inc = thi * dt + ((tlo * dt) >>> 24);
        acc = longint'(integ_q) + inc;
        if (acc > ACC_MAX) begin
            acc = ACC_MAX;
            sat_hits++;
        end
        if (acc < ACC_MIN) begin
            acc = ACC_MIN;
            sat_hits++;
        end
        integ_q = 32'(acc);
        r.drive = 16'((sat + 32768) >>> 16);
        return r;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_error();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 4095)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN:     kp_set = val;
            REG_INTEGRAL_GAIN: ki_set = val;
            REG_WINDUP_GAIN:   kaw_set = val;
            REG_STEP_TIME:     dt_set = val;
            REG_DRIVE_MIN:     out_lo = val;
            REG_DRIVE_MAX:     out_hi = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one request and hold it until the transfer; the answer is queued on acceptance.
    task automatic offer(input logic rt, input logic signed [15:0] err, input logic typed,
                         input ctl_out_t want);
        ctl_out_t pred;
        in_valid <= 1'b1;
        req_type <= rt;
        loop_error <= err;
        do @(posedge clk); while (in_stall);
        pred = pi_predict(rt, err);
        expected_q.push_back(typed ? want : pred);
        items_sent++;
        if (rt == REQ_CLEAR)
            clears_sent++;
    endtask

    task automatic idle_sender();
        int gap;
        gap = send_gaps ? int'($urandom_range(0, 5)) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers change only once every result is out and the sequencer is home again.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        logic signed [15:0] lo_lim;
        logic signed [15:0] hi_lim;
        logic signed [15:0] swap;
        logic               rt;
        errors = 0;
        items_sent = 0;
        clears_sent = 0;
        reg_writes = 0;
        results_seen = 0;
        clamp_hits = 0;
        sat_hits = 0;
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        long_hold_req = 1'b0;
        kp_set = 16'h0100;
        ki_set = 16'h0000;
        kaw_set = 16'h0000;
        dt_set = 16'h0000;
        out_lo = 16'sh8000;
        out_hi = 16'sh7FFF;
        integ_q = '0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PROP_GAIN;
        cfg_data <= 16'h0000;
        in_valid <= 1'b0;
        req_type <= REQ_STEP;
        loop_error <= 16'sd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_WRITE) begin
                settle();
                write_reg(PLAN[i].idx, PLAN[i].data);
            end else begin
                offer(PLAN[i].rt, PLAN[i].err, PLAN[i].typed, PLAN[i].want);
                idle_sender();
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            send_gaps = (phase % 3) != 2;
            recv_gaps = (phase % 4) != 3;
            settle();
            write_reg(REG_PROP_GAIN, pick_gain());
            write_reg(REG_INTEGRAL_GAIN, pick_gain());
            write_reg(REG_WINDUP_GAIN, pick_gain());
            write_reg(REG_STEP_TIME, pick_gain());
            lo_lim = 16'($urandom);
            hi_lim = 16'($urandom);
            case ($urandom_range(0, 3))
                0: begin
                    lo_lim = 16'sh8000;
                    hi_lim = 16'sh7FFF;
                end
                1: if (lo_lim > hi_lim) begin
                    swap = lo_lim;
                    lo_lim = hi_lim;
                    hi_lim = swap;
                end
                2: if (lo_lim < hi_lim) begin
                    swap = lo_lim;
                    lo_lim = hi_lim;
                    hi_lim = swap;
                end
                default: ;
            endcase
            write_reg(REG_DRIVE_MIN, lo_lim);
            write_reg(REG_DRIVE_MAX, hi_lim);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The receiver holds off while requests keep coming, so the block backs up.
                if (phase == 3 && n == 10)
                    long_hold_req = 1'b1;
                if (phase == 6 && n == 25) begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (expected_q.size() != 0);
                end
                rt = ($urandom_range(0, 11) == 0) ? REQ_CLEAR : REQ_STEP;
                offer(rt, pick_error(), 1'b0, '0);
                idle_sender();
            end
        end

        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d clears) under %0d register writes; %0d results checked.",
                 items_sent, clears_sent, reg_writes, results_seen);
        $display("Predicted %0d clamped outputs and %0d integrator saturations.",
                 clamp_hits, sat_hits);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : result_side
        int hold_left;
        int long_left;
        ctl_out_t want;
        hold_left = 0;
        long_left = 0;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result drive %0d clamped %0b", $time, drive, clamped);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (drive !== want.drive) begin
                        $display("%0t: drive expected %0d actual %0d", $time, want.drive, drive);
                        errors++;
                    end
                    if (clamped !== want.clamped) begin
                        $display("%0t: clamped expected %0b actual %0b",
                                 $time, want.clamped, clamped);
                        errors++;
                    end
                end
                hold_left = recv_gaps ? int'($urandom_range(0, 5)) : 0;
            end else if (out_valid && hold_left > 0) begin
                hold_left--;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                long_left = LONG_HOLD;
            end
            if (long_left > 0)
                long_left--;
            out_stall <= (hold_left > 0) || (long_left > 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
src/pica_pkg.sv
src/pi_controller_antiwindup.sv
src/pica_checker.sv
verif/testbench.sv
